// ----- hdl/srtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int SLOT_F_W = 4;
    localparam int TIME_F_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SLOT_F_W-1:0] slot;
        logic [TIME_F_W-1:0] arrive_at;
        logic [TIME_F_W-1:0] run_len;
    } t_sched_in;

    typedef struct packed {
        logic                ran;
        logic [SLOT_F_W-1:0] chosen_slot;
        logic                finished;
        logic [TIME_F_W-1:0] turnaround;
        logic [TIME_F_W-1:0] waiting;
        logic [TIME_F_W-1:0] clock_now;
        logic                all_done;
    } t_sched_out;

endpackage
`default_nettype wire

// ----- hdl/srtf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srtf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/srtf_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_alu
// Shared two-lane subtractor; each lane gives the difference and the borrow,
// so it serves as both compare and arithmetic for the sequencer.
// ----------------------------------------------------------------------------
module srtf_alu #(
    parameter int W = 16
) (
    input  wire logic [W-1:0] i_a_x,
    input  wire logic [W-1:0] i_a_y,
    input  wire logic [W-1:0] i_b_x,
    input  wire logic [W-1:0] i_b_y,
    output logic      [W-1:0] o_a_diff,
    output logic              o_a_borrow,
    output logic      [W-1:0] o_b_diff,
    output logic              o_b_borrow
);

    assign {o_a_borrow, o_a_diff} = {1'b0, i_a_x} - {1'b0, i_a_y};
    assign {o_b_borrow, o_b_diff} = {1'b0, i_b_x} - {1'b0, i_b_y};

endmodule
`default_nettype wire

// ----- hdl/srtf_preemptive_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler
// Job slot table with preemptive shortest-remaining-time-first selection.
// ----------------------------------------------------------------------------
//  channel   ports                      transfer
//  command   i_start, o_busy, i_cmd     edge with i_start high and o_busy low
//  result    o_valid, o_result          every cycle o_valid is high
//
//  load, restart and unknown items: result strobed the cycle after the transfer
//  tick: busy through the scan (one RAM read per slot through the shared
//  subtractor), the drain and the update, then a final state when the chosen
//  job completes (waiting time takes a second pass through the subtractor)
//  reset clears the clock, pending flags and sequencer; the slot RAM is not
//  cleared, only pending slots are ever selected
//  results cannot be stalled; o_valid is high for exactly one cycle
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler #(
    parameter int SLOTS     = srtf_pkg::SLOTS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire srtf_pkg::t_sched_in  i_cmd,
    output logic                      o_valid,
    output srtf_pkg::t_sched_out      o_result
);

    import srtf_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TB     = TIME_BITS;
    localparam int WORD_W = 3 * TB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPD,
        ST_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [TB-1:0]     r_clock, n_clock;
    logic [SLOTS-1:0]  r_pending, n_pending;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic              r_cmp_v, n_cmp_v;
    logic              r_best_v, n_best_v;
    logic [SLOT_W-1:0] r_best, n_best;
    logic [TB-1:0]     r_best_arr, n_best_arr;
    logic [TB-1:0]     r_best_bur, n_best_bur;
    logic [TB-1:0]     r_best_rem, n_best_rem;
    logic [TB-1:0]     r_tat, n_tat;
    logic              r_valid, n_valid;
    t_sched_out        r_out, n_out;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [TB-1:0]     rd_arr, rd_bur, rd_rem;

    logic [TB-1:0]     alu_a_x, alu_a_y, alu_b_x, alu_b_y;
    logic [TB-1:0]     alu_a_diff, alu_b_diff;
    logic              alu_a_borrow, alu_b_borrow;

    logic [TB-1:0]     clk_next;
    logic [TB-1:0]     ld_arr, ld_bur;
    logic              take;

    srtf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    srtf_alu #(
        .W (TB)
    ) u_alu (
        .i_a_x      (alu_a_x),
        .i_a_y      (alu_a_y),
        .i_b_x      (alu_b_x),
        .i_b_y      (alu_b_y),
        .o_a_diff   (alu_a_diff),
        .o_a_borrow (alu_a_borrow),
        .o_b_diff   (alu_b_diff),
        .o_b_borrow (alu_b_borrow)
    );

    assign rd_arr   = ram_rdata[3*TB-1:2*TB];
    assign rd_bur   = ram_rdata[2*TB-1:TB];
    assign rd_rem   = ram_rdata[TB-1:0];
    assign ld_arr   = TB'(i_cmd.arrive_at);
    assign ld_bur   = TB'(i_cmd.run_len);
    assign clk_next = (r_clock == {TB{1'b1}}) ? r_clock : r_clock + TB'(1);

    // operand select for the shared subtractor
    always_comb begin
        alu_a_x = '0;
        alu_a_y = '0;
        alu_b_x = '0;
        alu_b_y = '0;
        case (r_state)
            ST_SCAN, ST_DRAIN: begin
                alu_a_x = r_clock;
                alu_a_y = rd_arr;
                alu_b_x = rd_rem;
                alu_b_y = r_best_rem;
            end
            ST_UPD: begin
                alu_a_x = clk_next;
                alu_a_y = r_best_arr;
                alu_b_x = r_best_rem;
                alu_b_y = TB'(1);
            end
            ST_FIN: begin
                alu_a_x = r_tat;
                alu_a_y = r_best_bur;
            end
            default: begin
            end
        endcase
    end

    // eligible: pending and arrived; strict less keeps the lowest slot on ties
    assign take = r_cmp_v && r_pending[r_cmp_idx] && !alu_a_borrow
                  && (!r_best_v || alu_b_borrow);

    always_comb begin
        n_state    = r_state;
        n_clock    = r_clock;
        n_pending  = r_pending;
        n_idx      = r_idx;
        n_cmp_idx  = r_cmp_idx;
        n_cmp_v    = r_cmp_v;
        n_best_v   = r_best_v;
        n_best     = r_best;
        n_best_arr = r_best_arr;
        n_best_bur = r_best_bur;
        n_best_rem = r_best_rem;
        n_tat      = r_tat;
        n_valid    = 1'b0;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_best;
        ram_wdata  = {r_best_arr, r_best_bur, alu_b_diff};

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_out = '0;
                    case (i_cmd.func)
                        FUNC_LOAD: begin
                            if ({28'd0, i_cmd.slot} < 32'(SLOTS)) begin
                                ram_we    = 1'b1;
                                ram_waddr = SLOT_W'(i_cmd.slot);
                                ram_wdata = {ld_arr, ld_bur, ld_bur};
                                n_pending[SLOT_W'(i_cmd.slot)] = (ld_bur != '0);
                            end
                            n_valid = 1'b1;
                        end
                        FUNC_TICK: begin
                            n_idx    = '0;
                            n_cmp_v  = 1'b0;
                            n_best_v = 1'b0;
                            n_state  = ST_SCAN;
                        end
                        FUNC_RESTART: begin
                            n_clock = '0;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                    n_out.clock_now = TIME_F_W'(n_clock);
                    n_out.all_done  = (n_pending == '0);
                end
            end
            ST_SCAN, ST_DRAIN: begin
                if (take) begin
                    n_best_v   = 1'b1;
                    n_best     = r_cmp_idx;
                    n_best_arr = rd_arr;
                    n_best_bur = rd_bur;
                    n_best_rem = rd_rem;
                end
                n_cmp_idx = r_idx;
                n_cmp_v   = (r_state == ST_SCAN);
                if (r_state == ST_DRAIN) begin
                    n_state = ST_UPD;
                end else if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            ST_UPD: begin
                n_clock         = clk_next;
                n_out           = '0;
                n_out.clock_now = TIME_F_W'(clk_next);
                if (r_best_v) begin
                    ram_we            = 1'b1;
                    n_out.ran         = 1'b1;
                    n_out.chosen_slot = SLOT_F_W'(r_best);
                    if (alu_b_diff == '0) begin
                        n_pending[r_best] = 1'b0;
                        n_tat             = alu_a_diff;
                        n_out.finished    = 1'b1;
                        n_out.turnaround  = TIME_F_W'(alu_a_diff);
                    end
                end
                n_out.all_done = (n_pending == '0);
                if (r_best_v && alu_b_diff == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FIN: begin
                // waiting time floors at zero once the clock has saturated
                n_out.waiting = alu_a_borrow ? '0 : TIME_F_W'(alu_a_diff);
                n_valid       = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_clock   <= '0;
            r_pending <= '0;
            r_cmp_v   <= 1'b0;
            r_best_v  <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clock   <= n_clock;
            r_pending <= n_pending;
            r_cmp_v   <= n_cmp_v;
            r_best_v  <= n_best_v;
            r_valid   <= n_valid;
        end
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_best     <= n_best;
        r_best_arr <= n_best_arr;
        r_best_bur <= n_best_bur;
        r_best_rem <= n_best_rem;
        r_tat      <= n_tat;
        r_out      <= n_out;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ----- tb/srtf_preemptive_scheduler_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler_test
// Self-checking bench for the shortest-remaining-time-first scheduler: a
// queue-fed command driver, a result monitor and a scoreboard backed by a
// behavioral copy of the slot table, fed with directed corner cases, job sets
// of loads and ticks and random noise, with several sender idle phases.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler_test;
    import srtf_pkg::*;

    typedef struct {
        t_sched_in   cmd;
        int unsigned idle_pct;
        bit          drain;
    } t_cmd_entry;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_sched_in   i_cmd;
    logic        o_valid;
    t_sched_out  o_result;

    // behavioral slot table
    logic [15:0] sched_clock;
    logic [15:0] job_pending;
    logic [15:0] job_arrival [16];
    logic [15:0] job_left    [16];
    logic [15:0] job_burst   [16];

    t_cmd_entry  cmd_queue[$];
    t_sched_out  sched_expect[$];
    bit          cmd_taken;
    int unsigned cur_idle_pct;
    bit          drain_next;
    int          items_queued;
    int          fail_count;
    int          items_sent;
    int          ticks_ran;
    int          ticks_idle;
    int          jobs_finished;

    srtf_preemptive_scheduler i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_sched_out predict_sched(input t_sched_in c);
        t_sched_out  r;
        int          best;
        logic [15:0] span;
        r = '0;
        best = -1;
        case (c.func)
            FUNC_LOAD: begin
                job_arrival[c.slot] = c.arrive_at;
                job_burst[c.slot]   = c.run_len;
                job_left[c.slot]    = c.run_len;
                job_pending[c.slot] = (c.run_len != 16'd0);
            end
            FUNC_TICK: begin
                for (int i = 0; i < 16; i++) begin
                    if (job_pending[i] && job_arrival[i] <= sched_clock &&
                        (best < 0 || job_left[i] < job_left[best]))
                        best = i;
                end
                if (sched_clock != 16'hFFFF)
                    sched_clock = sched_clock + 16'd1;
                if (best >= 0) begin
                    r.ran         = 1'b1;
                    r.chosen_slot = best[3:0];
                    job_left[best] = job_left[best] - 16'd1;
                    if (job_left[best] == 16'd0) begin
                        span = sched_clock - job_arrival[best];
                        job_pending[best] = 1'b0;
                        r.finished   = 1'b1;
                        r.turnaround = span;
                        r.waiting    = (span >= job_burst[best]) ? span - job_burst[best] : '0;
                    end
                end
            end
            FUNC_RESTART: begin
                sched_clock = '0;
            end
            default: ;
        endcase
        r.clock_now = sched_clock;
        r.all_done  = (job_pending == '0);
        return r;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_cmd(input logic [1:0] f, input int unsigned s,
                             input int unsigned arr, input int unsigned bur);
        t_cmd_entry e;
        e.cmd.func      = f;
        e.cmd.slot      = s[3:0];
        e.cmd.arrive_at = arr[15:0];
        e.cmd.run_len   = bur[15:0];
        e.idle_pct      = cur_idle_pct;
        e.drain         = drain_next;
        drain_next = 1'b0;
        cmd_queue.push_back(e);
        items_queued++;
    endtask

    // optional clear of all slots, restart, two to six jobs arriving early, then ticks and some extra job loads
    task automatic add_job_set();
        int          n_jobs;
        int          work;
        int unsigned b;
        if ($urandom_range(3) == 0) begin
            for (int s = 0; s < 16; s++)
                queue_cmd(FUNC_LOAD, s, $urandom, 0);
        end
        queue_cmd(FUNC_RESTART, $urandom, $urandom, $urandom);
        n_jobs = $urandom_range(6, 2);
        work = 0;
        for (int k = 0; k < n_jobs; k++) begin
            b = $urandom_range(6, 1);
            queue_cmd(FUNC_LOAD, $urandom_range(15), $urandom_range(8), b);
            work += b;
        end
        for (int k = 0; k < work + $urandom_range(3); k++) begin
            if ($urandom_range(9) == 0)
                queue_cmd(FUNC_LOAD, $urandom_range(15), $urandom_range(12),
                          $urandom_range(4, 1));
            else
                queue_cmd(FUNC_TICK, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(10, 4))
            queue_cmd(2'($urandom_range(3)), $urandom, $urandom, $urandom);
    endtask

    // driver: new command chosen at the falling edge once the last one transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !cmd_taken) begin
            // hold until transfer
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain && (sched_expect.size() != 0 || o_busy)) &&
                     $urandom_range(99) >= cmd_queue[0].idle_pct) begin
            i_start <= 1'b1;
            i_cmd   <= cmd_queue[0].cmd;
        end else begin
            i_start <= 1'b0;
        end
        cmd_taken = 1'b0;
    end

    // monitor: check strobed results, then predict for any command transfer
    always @(posedge i_clk) begin
        t_sched_out want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (sched_expect.size() == 0) begin
                    $display("%0t: unexpected result %0h", $time, o_result);
                    fail_count++;
                end else begin
                    want = sched_expect.pop_front();
                    report_field("ran", want.ran, o_result.ran);
                    report_field("chosen_slot", want.chosen_slot, o_result.chosen_slot);
                    report_field("finished", want.finished, o_result.finished);
                    report_field("turnaround", want.turnaround, o_result.turnaround);
                    report_field("waiting", want.waiting, o_result.waiting);
                    report_field("clock_now", want.clock_now, o_result.clock_now);
                    report_field("all_done", want.all_done, o_result.all_done);
                    if (want.ran) ticks_ran++;
                    if (want.finished) jobs_finished++;
                end
            end
            if (i_start && o_busy === 1'b0) begin
                want = predict_sched(i_cmd);
                if (i_cmd.func == FUNC_TICK && !want.ran) ticks_idle++;
                sched_expect.push_back(want);
                void'(cmd_queue.pop_front());
                items_sent++;
                cmd_taken = 1'b1;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_cmd         = '0;
        cmd_taken     = 1'b0;
        sched_clock   = '0;
        job_pending   = '0;
        fail_count    = 0;
        items_queued  = 0;
        items_sent    = 0;
        ticks_ran     = 0;
        ticks_idle    = 0;
        jobs_finished = 0;
        cur_idle_pct  = 0;
        drain_next    = 1'b0;
        for (int i = 0; i < 16; i++) begin
            job_arrival[i] = '0;
            job_left[i]    = '0;
            job_burst[i]   = '0;
        end

        // directed: idle tick, zero burst, extremes, ties, preemption, reload
        queue_cmd(FUNC_TICK, 0, 0, 0);
        queue_cmd(FUNC_LOAD, 0, 0, 0);
        queue_cmd(FUNC_LOAD, 15, 16'hFFFF, 16'hFFFF);
        queue_cmd(FUNC_LOAD, 3, 0, 3);
        queue_cmd(FUNC_LOAD, 1, 0, 3);
        queue_cmd(FUNC_LOAD, 2, 2, 1);
        queue_cmd(2'd3, 15, 16'hFFFF, 16'hFFFF);
        queue_cmd(FUNC_RESTART, 0, 0, 0);
        repeat (9) queue_cmd(FUNC_TICK, 0, 0, 0);
        drain_next = 1'b1;
        queue_cmd(FUNC_LOAD, 1, 0, 2);
        queue_cmd(FUNC_LOAD, 1, 0, 1);
        queue_cmd(FUNC_TICK, 0, 0, 0);
        queue_cmd(FUNC_LOAD, 15, 0, 0);
        queue_cmd(FUNC_TICK, 15, 16'hFFFF, 16'hFFFF);

        // random phases: sender idle 0, 87, 0, 36 percent
        for (int ph = 0; ph < 4; ph++) begin
            cur_idle_pct = (ph == 1) ? 87 : (ph == 3) ? 36 : 0;
            drain_next = 1'b1;
            while (items_queued < 25 + (ph + 1) * 235) begin
                if ($urandom_range(4) == 0) add_noise();
                else add_job_set();
            end
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || sched_expect.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run covered %0d commands: %0d ticks ran a job, %0d idle ticks,",
                 items_sent, ticks_ran, ticks_idle);
        $display("%0d job completions, with sender idle phases and a full drain",
                 jobs_finished);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
